// ----- design/bounding_sphere_merge_defines.svh -----
// Assertion macros shared by the bounding sphere merge RTL.
`ifndef BOUNDING_SPHERE_MERGE_DEFINES_SVH
`define BOUNDING_SPHERE_MERGE_DEFINES_SVH
`ifndef SYNTHESIS
`define BSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsm assertion failed");
`define BSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsm assertion failed");
`else
`define BSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/bsm_pkg.sv -----
// Types and constants shared by the bounding sphere merge pipeline.
package bsm_pkg;
    localparam int CW     = 24;          // coordinate width
    localparam int RW     = CW - 1;      // radius width
    localparam int DW     = CW + 1;      // centre difference magnitude width
    localparam int SW     = 2 * CW + 2;  // squared distance width
    localparam int QW     = CW + 1;      // distance and quotient width
    localparam int RMW    = QW + 3;      // square root remainder width
    localparam int MRW    = CW + 1;      // merged radius width
    localparam int GW     = 2 * CW + 2;  // growth width
    localparam int IN_TW  = 192;
    localparam int OUT_TW = 152;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic [RW-1:0]        t_rad;
    typedef logic [DW-1:0]        t_mag;
    typedef logic [SW-1:0]        t_sq;
    typedef logic [QW-1:0]        t_root;

    typedef struct packed {
        logic encl;
        logic ovl;
        logic a_big;
    } t_flag;

    typedef struct packed {
        t_coord [2:0] a;
        t_coord [2:0] b;
        t_mag [2:0]   absd;
        logic [2:0]   neg;
        t_rad         ra;
        t_rad         rb;
    } t_geo;

    typedef struct packed {
        t_geo  geo;
        t_flag flag;
    } t_side;

    typedef struct packed {
        t_geo            geo;
        t_flag           flag;
        logic [MRW-1:0]  r;
        logic [GW-1:0]   growth;
    } t_dside;
endpackage

// ----- design/bsm_front.sv -----
// Front stages: centre differences, squares, squared distance and case flags.
module bsm_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  bsm_pkg::t_coord [2:0]   i_a,
    input  bsm_pkg::t_coord [2:0]   i_b,
    input  bsm_pkg::t_rad           i_ra,
    input  bsm_pkg::t_rad           i_rb,
    output logic                    o_ready,
    input  logic                    i_adv,
    output logic                    o_valid,
    output bsm_pkg::t_side          o_side,
    output bsm_pkg::t_sq            o_dist2
);
    logic [3:0] r_v;
    logic [4:0] w_en;

    bsm_pkg::t_geo r_g0, r_g1, r_g2, r_g3, n_g0;
    bsm_pkg::t_sq [2:0] r_sq1;
    logic [2*bsm_pkg::RW-1:0] r_rd2_1, r_rd2_2;
    logic [2*bsm_pkg::CW-1:0] r_rs2_1, r_rs2_2;
    logic r_abig1, r_abig2;
    bsm_pkg::t_sq r_dist2_2, r_dist2_3;
    bsm_pkg::t_flag r_f3;

    logic signed [bsm_pkg::DW-1:0] w_delta [3];
    bsm_pkg::t_rad w_rdiff;
    logic [bsm_pkg::CW-1:0] w_rsum;

    always_comb begin
        w_en[4] = i_adv;
        for (int j = 3; j >= 0; j--) begin
            w_en[j] = !r_v[j] || w_en[j+1];
        end
    end

    always_comb begin
        n_g0 = '0;
        n_g0.a = i_a;
        n_g0.b = i_b;
        n_g0.ra = i_ra;
        n_g0.rb = i_rb;
        for (int i = 0; i < 3; i++) begin
            w_delta[i] = $signed({i_b[i][bsm_pkg::CW-1], i_b[i]})
                       - $signed({i_a[i][bsm_pkg::CW-1], i_a[i]});
            n_g0.neg[i]  = w_delta[i][bsm_pkg::DW-1];
            n_g0.absd[i] = w_delta[i][bsm_pkg::DW-1] ? bsm_pkg::t_mag'(-w_delta[i])
                                                     : bsm_pkg::t_mag'(w_delta[i]);
        end
        w_rdiff = (r_g0.ra > r_g0.rb) ? r_g0.ra - r_g0.rb : r_g0.rb - r_g0.ra;
        w_rsum  = {1'b0, r_g0.ra} + {1'b0, r_g0.rb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < 4; j++) begin
                if (w_en[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_g0 <= n_g0;
        end
        if (w_en[1]) begin
            r_g1 <= r_g0;
            for (int i = 0; i < 3; i++) begin
                r_sq1[i] <= r_g0.absd[i] * r_g0.absd[i];
            end
            r_rd2_1 <= w_rdiff * w_rdiff;
            r_rs2_1 <= w_rsum * w_rsum;
            r_abig1 <= r_g0.ra > r_g0.rb;
        end
        if (w_en[2]) begin
            r_g2      <= r_g1;
            r_dist2_2 <= r_sq1[0] + r_sq1[1] + r_sq1[2];
            r_rd2_2   <= r_rd2_1;
            r_rs2_2   <= r_rs2_1;
            r_abig2   <= r_abig1;
        end
        if (w_en[3]) begin
            r_g3       <= r_g2;
            r_dist2_3  <= r_dist2_2;
            r_f3.encl  <= {4'b0, r_rd2_2} >= r_dist2_2;
            r_f3.ovl   <= r_dist2_2 < {2'b0, r_rs2_2};
            r_f3.a_big <= r_abig2;
        end
    end

    assign o_ready      = w_en[0];
    assign o_valid      = r_v[3];
    assign o_side.geo   = r_g3;
    assign o_side.flag  = r_f3;
    assign o_dist2      = r_dist2_3;
endmodule

// ----- design/bsm_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module bsm_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bsm_pkg::t_side  i_side,
    input  bsm_pkg::t_sq    i_rad,
    output logic            o_ready,
    input  logic            i_adv,
    output logic            o_valid,
    output bsm_pkg::t_side  o_side,
    output bsm_pkg::t_root  o_root
);
    typedef struct packed {
        logic [bsm_pkg::RMW-1:0] rem;
        bsm_pkg::t_root          root;
        bsm_pkg::t_sq            rad;
        bsm_pkg::t_side          side;
    } t_st;

    t_st r_st [bsm_pkg::QW];
    t_st w_cur [bsm_pkg::QW];
    t_st w_nxt [bsm_pkg::QW];
    logic [bsm_pkg::QW-1:0] r_v;
    logic [bsm_pkg::QW:0]   w_en;
    logic [bsm_pkg::RMW-1:0] w_cand [bsm_pkg::QW];
    logic [bsm_pkg::RMW-1:0] w_trial [bsm_pkg::QW];

    always_comb begin
        w_en[bsm_pkg::QW] = i_adv;
        for (int j = bsm_pkg::QW - 1; j >= 0; j--) begin
            w_en[j] = !r_v[j] || w_en[j+1];
        end
    end

    // Each stage brings down two radicand bits and decides one root bit.
    always_comb begin
        w_cur[0].rem  = '0;
        w_cur[0].root = '0;
        w_cur[0].rad  = i_rad;
        w_cur[0].side = i_side;
        for (int j = 1; j < bsm_pkg::QW; j++) begin
            w_cur[j] = r_st[j-1];
        end
        for (int j = 0; j < bsm_pkg::QW; j++) begin
            w_cand[j]  = {w_cur[j].rem[bsm_pkg::RMW-3:0], w_cur[j].rad[bsm_pkg::SW-1 -: 2]};
            w_trial[j] = {1'b0, w_cur[j].root, 2'b01};
            w_nxt[j]   = w_cur[j];
            w_nxt[j].rad = {w_cur[j].rad[bsm_pkg::SW-3:0], 2'b00};
            if (w_cand[j] >= w_trial[j]) begin
                w_nxt[j].rem  = w_cand[j] - w_trial[j];
                w_nxt[j].root = {w_cur[j].root[bsm_pkg::QW-2:0], 1'b1};
            end else begin
                w_nxt[j].rem  = w_cand[j];
                w_nxt[j].root = {w_cur[j].root[bsm_pkg::QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < bsm_pkg::QW; j++) begin
                if (w_en[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < bsm_pkg::QW; j++) begin
            if (w_en[j]) begin
                r_st[j] <= w_nxt[j];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[bsm_pkg::QW-1];
    assign o_side  = r_st[bsm_pkg::QW-1].side;
    assign o_root  = r_st[bsm_pkg::QW-1].root;
endmodule

// ----- design/bsm_div.sv -----
// Pipelined restoring divider for the three centre shifts, one quotient bit per stage.
module bsm_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  bsm_pkg::t_dside         i_side,
    input  bsm_pkg::t_sq [2:0]      i_num,
    input  bsm_pkg::t_root          i_den,
    output logic                    o_ready,
    input  logic                    i_adv,
    output logic                    o_valid,
    output bsm_pkg::t_dside         o_side,
    output bsm_pkg::t_root [2:0]    o_quo
);
    typedef struct packed {
        bsm_pkg::t_root [2:0] rem;
        bsm_pkg::t_root [2:0] lo;
        bsm_pkg::t_root [2:0] q;
        bsm_pkg::t_root       den;
        bsm_pkg::t_dside      side;
    } t_dv;

    t_dv r_st [bsm_pkg::QW];
    t_dv w_cur [bsm_pkg::QW];
    t_dv w_nxt [bsm_pkg::QW];
    logic [bsm_pkg::QW-1:0] r_v;
    logic [bsm_pkg::QW:0]   w_en;
    logic [bsm_pkg::QW:0]   w_cand [bsm_pkg::QW][3];

    always_comb begin
        w_en[bsm_pkg::QW] = i_adv;
        for (int j = bsm_pkg::QW - 1; j >= 0; j--) begin
            w_en[j] = !r_v[j] || w_en[j+1];
        end
    end

    // The quotient fits QW bits, so the upper numerator half is already below the divisor.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_cur[0].rem[i] = i_num[i][bsm_pkg::SW-1:bsm_pkg::QW];
            w_cur[0].lo[i]  = i_num[i][bsm_pkg::QW-1:0];
        end
        w_cur[0].q    = '0;
        w_cur[0].den  = i_den;
        w_cur[0].side = i_side;
        for (int j = 1; j < bsm_pkg::QW; j++) begin
            w_cur[j] = r_st[j-1];
        end
        for (int j = 0; j < bsm_pkg::QW; j++) begin
            w_nxt[j] = w_cur[j];
            for (int i = 0; i < 3; i++) begin
                w_cand[j][i] = {w_cur[j].rem[i], w_cur[j].lo[i][bsm_pkg::QW-1]};
                w_nxt[j].lo[i] = {w_cur[j].lo[i][bsm_pkg::QW-2:0], 1'b0};
                if (w_cand[j][i] >= {1'b0, w_cur[j].den}) begin
                    w_nxt[j].rem[i] = bsm_pkg::t_root'(w_cand[j][i] - {1'b0, w_cur[j].den});
                    w_nxt[j].q[i]   = {w_cur[j].q[i][bsm_pkg::QW-2:0], 1'b1};
                end else begin
                    w_nxt[j].rem[i] = w_cand[j][i][bsm_pkg::QW-1:0];
                    w_nxt[j].q[i]   = {w_cur[j].q[i][bsm_pkg::QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < bsm_pkg::QW; j++) begin
                if (w_en[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < bsm_pkg::QW; j++) begin
            if (w_en[j]) begin
                r_st[j] <= w_nxt[j];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[bsm_pkg::QW-1];
    assign o_side  = r_st[bsm_pkg::QW-1].side;
    assign o_quo   = r_st[bsm_pkg::QW-1].q;
endmodule

// ----- design/bounding_sphere_merge.sv -----
// Stage order: front, square root, merge stages m0 and m1, divider, output register.
// Throughput: one sphere pair per cycle while the output is not held off by i_m_tready;
// every stage has its own valid bit and takes new data whenever it is empty or its successor advances.
// The 25-stage square root and the 25-stage divider set the latency.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// Top level of the bounding sphere union and overlap pipeline.
`include "bounding_sphere_merge_defines.svh"
module bounding_sphere_merge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius, two zero pad bits
    input  logic [bsm_pkg::IN_TW-1:0]    i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // merged_x, merged_y, merged_z, merged_radius, overlap, growth, four zero pad bits
    output logic [bsm_pkg::OUT_TW-1:0]   o_m_tdata
);
    bsm_pkg::t_coord [2:0] w_a, w_b;
    bsm_pkg::t_rad w_ra, w_rb;

    logic w_fr_ready, w_fr_valid;
    bsm_pkg::t_side w_fr_side;
    bsm_pkg::t_sq w_fr_dist2;

    logic w_sq_ready, w_sq_valid;
    bsm_pkg::t_side w_sq_side;
    bsm_pkg::t_root w_sq_root;

    logic r_m0_v, r_m1_v, w_en_m0, w_en_m1;
    bsm_pkg::t_side r_m0_side, r_m1_side;
    logic [bsm_pkg::MRW-1:0] r_m0_r, r_m0_k, r_m1_r, n_m0_r;
    bsm_pkg::t_root r_m0_d, r_m1_d;
    logic [bsm_pkg::MRW:0] w_rsum;
    bsm_pkg::t_sq [2:0] r_m1_prod;
    logic [2*bsm_pkg::MRW-1:0] r_m1_rsq;
    logic [2*bsm_pkg::RW-1:0] r_m1_rasq;
    bsm_pkg::t_dside w_dv_in;

    logic w_dv_ready, w_dv_valid;
    bsm_pkg::t_dside w_dv_side;
    bsm_pkg::t_root [2:0] w_dv_quo;

    logic r_ov, w_en_out;
    bsm_pkg::t_coord [2:0] r_mc, n_mc;
    logic [bsm_pkg::CW+1:0] w_shift [3];
    logic [bsm_pkg::MRW-1:0] r_mr;
    logic r_ovl;
    logic [bsm_pkg::GW-1:0] r_growth;
    bsm_pkg::t_flag r_oflag;

    assign w_a[0] = i_s_tdata[23:0];
    assign w_a[1] = i_s_tdata[47:24];
    assign w_a[2] = i_s_tdata[71:48];
    assign w_ra   = i_s_tdata[94:72];
    assign w_b[0] = i_s_tdata[118:95];
    assign w_b[1] = i_s_tdata[142:119];
    assign w_b[2] = i_s_tdata[166:143];
    assign w_rb   = i_s_tdata[189:167];

    assign w_en_out = !r_ov || i_m_tready;
    assign w_en_m1  = !r_m1_v || w_dv_ready;
    assign w_en_m0  = !r_m0_v || w_en_m1;

    bsm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_ra    (w_ra),
        .i_rb    (w_rb),
        .o_ready (w_fr_ready),
        .i_adv   (w_sq_ready),
        .o_valid (w_fr_valid),
        .o_side  (w_fr_side),
        .o_dist2 (w_fr_dist2)
    );

    bsm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .i_side  (w_fr_side),
        .i_rad   (w_fr_dist2),
        .o_ready (w_sq_ready),
        .i_adv   (w_en_m0),
        .o_valid (w_sq_valid),
        .o_side  (w_sq_side),
        .o_root  (w_sq_root)
    );

    // Merged radius: the larger sphere when one holds the other, else half the span.
    always_comb begin
        w_rsum = {1'b0, w_sq_root} + {3'b0, w_sq_side.geo.ra} + {3'b0, w_sq_side.geo.rb};
        if (w_sq_side.flag.encl) begin
            n_m0_r = w_sq_side.flag.a_big ? {2'b0, w_sq_side.geo.ra} : {2'b0, w_sq_side.geo.rb};
        end else begin
            n_m0_r = w_rsum[bsm_pkg::MRW:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0_v <= 1'b0;
            r_m1_v <= 1'b0;
        end else begin
            if (w_en_m0) begin
                r_m0_v <= w_sq_valid;
            end
            if (w_en_m1) begin
                r_m1_v <= r_m0_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_m0) begin
            r_m0_side <= w_sq_side;
            r_m0_r    <= n_m0_r;
            r_m0_k    <= n_m0_r - {2'b0, w_sq_side.geo.ra};
            r_m0_d    <= w_sq_root;
        end
        if (w_en_m1) begin
            r_m1_side <= r_m0_side;
            r_m1_r    <= r_m0_r;
            r_m1_d    <= r_m0_d;
            for (int i = 0; i < 3; i++) begin
                r_m1_prod[i] <= r_m0_side.geo.absd[i] * r_m0_k;
            end
            r_m1_rsq  <= r_m0_r * r_m0_r;
            r_m1_rasq <= r_m0_side.geo.ra * r_m0_side.geo.ra;
        end
    end

    always_comb begin
        w_dv_in.geo    = r_m1_side.geo;
        w_dv_in.flag   = r_m1_side.flag;
        w_dv_in.r      = r_m1_r;
        w_dv_in.growth = r_m1_rsq - {4'b0, r_m1_rasq};
    end

    bsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m1_v),
        .i_side  (w_dv_in),
        .i_num   (r_m1_prod),
        .i_den   (r_m1_d),
        .o_ready (w_dv_ready),
        .i_adv   (w_en_out),
        .o_valid (w_dv_valid),
        .o_side  (w_dv_side),
        .o_quo   (w_dv_quo)
    );

    // The shift toward B is truncated toward zero, so it is applied as a signed magnitude.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_dv_side.geo.neg[i]) begin
                w_shift[i] = {{2{w_dv_side.geo.a[i][bsm_pkg::CW-1]}}, w_dv_side.geo.a[i]}
                           - {1'b0, w_dv_quo[i]};
            end else begin
                w_shift[i] = {{2{w_dv_side.geo.a[i][bsm_pkg::CW-1]}}, w_dv_side.geo.a[i]}
                           + {1'b0, w_dv_quo[i]};
            end
            if (w_dv_side.flag.encl) begin
                n_mc[i] = w_dv_side.flag.a_big ? w_dv_side.geo.a[i] : w_dv_side.geo.b[i];
            end else begin
                n_mc[i] = w_shift[i][bsm_pkg::CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en_out) begin
            r_ov <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_mc     <= n_mc;
            r_mr     <= w_dv_side.r;
            r_ovl    <= w_dv_side.flag.ovl;
            r_growth <= w_dv_side.growth;
            r_oflag  <= w_dv_side.flag;
        end
    end

    assign o_s_tready = w_fr_ready;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {4'b0, r_growth, r_ovl, r_mr, r_mc[2], r_mc[1], r_mc[0]};

    `BSM_ASSERT_IMPL(a_den_nonzero, i_clk, i_rst_n, r_m1_v && !r_m1_side.flag.encl, r_m1_d != '0)
    `BSM_ASSERT_IMPL(a_quo_bound, i_clk, i_rst_n, w_dv_valid && !w_dv_side.flag.encl, (w_dv_quo[0] <= w_dv_side.geo.absd[0]) && (w_dv_quo[1] <= w_dv_side.geo.absd[1]) && (w_dv_quo[2] <= w_dv_side.geo.absd[2]))
    `BSM_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, !o_s_tready, o_m_tvalid && !i_m_tready)
    `BSM_ASSERT_IMPL(a_growth_zero, i_clk, i_rst_n, r_ov && r_oflag.encl && r_oflag.a_big, r_growth == '0)
endmodule
